// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL. Empty in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// File: sv/mbrtu_pkg.sv
`timescale 1ns / 1ps

package mbrtu_pkg;

  localparam int FRAME_MAX = 256;
  localparam int ADDR_W    = $clog2(FRAME_MAX);
  localparam int CNT_W     = $clog2(FRAME_MAX + 1);
  localparam int LEN_W     = 9;

  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [15:0] SIL_RESET = 16'd35;

  typedef enum logic [2:0] {
    OP_RX_BYTE  = 3'd0,
    OP_TX_READY = 3'd1,
    OP_TICK     = 3'd2,
    OP_LOAD     = 3'd3,
    OP_SEND     = 3'd4,
    OP_READ     = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    LINK_RX_IDLE = 2'd0,
    LINK_RX_RCV  = 2'd1,
    LINK_TX_XMIT = 2'd2
  } link_state_t;

  typedef enum logic [1:0] {
    POLL_IDLE  = 2'd0,
    POLL_XMIT  = 2'd1,
    POLL_WAIT  = 2'd2,
    POLL_READY = 2'd3
  } poll_state_t;

  // Result word while the buffer read is in flight.
  typedef struct packed {
    logic        tx_valid;
    logic        tx_from_ram;
    logic [7:0]  tx_byte;
    logic        frame_done;
    logic        frame_ok;
    logic [7:0]  slave_addr;
    logic [7:0]  func_code;
    logic [7:0]  payload_len;
    logic        rd_from_ram;
    poll_state_t poll_phase;
    logic        send_refused;
    logic        rx_enabled;
  } res_t;

  // Modbus CRC16 update, reflected, one byte.
  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: sv/mbrtu_ram.sv
`timescale 1ns / 1ps

module mbrtu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/modbus_rtu_master_framer.sv
`timescale 1ns / 1ps
// Modbus RTU master link layer: one event word (line byte, transmitter ready, 50 us tick,
// host load, send start, buffer read) in, one result word out. An event is taken every
// cycle while in_stall is low. Its result passes through a result stage and the output
// register, with the registered read of the 256-byte frame buffer RAM in between, so
// the input keeps flowing while a result waits. Bytes 0 and 1 of the buffer are mirrored
// in flops so a frame report and a send start need no RAM access. cfg_ready is always high;
// write silence_ticks only while no event is in flight, which the block does not enforce.
`include "assert_macros.svh"

module modbus_rtu_master_framer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [7:0]  in_data,
  input  logic [7:0]  in_index,
  input  logic [8:0]  in_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_byte,
  output logic        out_frame_done,
  output logic        out_frame_ok,
  output logic [7:0]  out_slave_addr,
  output logic [7:0]  out_func_code,
  output logic [7:0]  out_payload_len,
  output logic [7:0]  out_read_data,
  output logic [1:0]  out_poll_phase,
  output logic        out_send_refused,
  output logic        out_rx_enabled
);
  import mbrtu_pkg::*;

  logic [15:0]       silence_ticks_r;
  link_state_t       link_r, link_nxt;
  poll_state_t       poll_r, poll_nxt;
  logic [CNT_W-1:0]  rx_count_r, rx_count_nxt;
  logic [LEN_W-1:0]  tx_pos_r, tx_pos_nxt;
  logic [LEN_W-1:0]  tx_rem_r, tx_rem_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic [15:0]       sil_cnt_r, sil_cnt_nxt;
  logic              timer_r, timer_nxt;
  logic [7:0]        byte0_r, byte1_r;

  logic              s1_valid_r;
  res_t              s1_r, res_nxt;
  logic              out_valid_r;
  res_t              out_r;
  logic [7:0]        out_tx_byte_r, out_rd_r;

  logic              in_acc, adv_out, adv_s1;
  op_t               op;
  logic              idx_ok, rx_store, tx_more, expire, report;
  logic [15:0]       limit, sil_inc;
  logic [LEN_W-1:0]  send_len;
  logic [CNT_W-1:0]  rx_base;
  logic [15:0]       crc_base;
  logic              ram_en, ram_we;
  logic [ADDR_W-1:0] ram_addr, wr_addr;
  logic [7:0]        ram_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      silence_ticks_r <= SIL_RESET;
    end else if (cfg_valid) begin
      silence_ticks_r <= cfg_data;
    end
  end

  // Two-stage flow: result stage then output register.
  assign adv_out  = !out_valid_r || !out_stall;
  assign adv_s1   = !s1_valid_r || adv_out;
  assign in_stall = !adv_s1;
  assign in_acc   = in_valid && adv_s1;

  assign op      = op_t'(in_op);
  assign idx_ok  = ({1'b0, in_index} < 9'(FRAME_MAX));
  assign tx_more = (tx_rem_r != '0);
  assign limit   = (silence_ticks_r == '0) ? 16'd1 : silence_ticks_r;
  assign sil_inc = (sil_cnt_r != 16'hFFFF) ? sil_cnt_r + 16'd1 : sil_cnt_r;
  assign expire  = timer_r && (sil_inc >= limit);
  assign report  = (link_r == LINK_RX_RCV) && (poll_r == POLL_WAIT);

  // A byte in idle starts a fresh frame.
  assign rx_base  = (link_r == LINK_RX_IDLE) ? '0 : rx_count_r;
  assign crc_base = (link_r == LINK_RX_IDLE) ? CRC_INIT : crc_r;
  assign rx_store = (link_r != LINK_TX_XMIT) && (rx_base < CNT_W'(FRAME_MAX));
  assign wr_addr  = (op == OP_LOAD) ? in_index[ADDR_W-1:0] : rx_base[ADDR_W-1:0];

  always_comb begin
    if (in_length == '0) begin
      send_len = LEN_W'(1);
    end else if (in_length > LEN_W'(FRAME_MAX)) begin
      send_len = LEN_W'(FRAME_MAX);
    end else begin
      send_len = in_length;
    end
  end

  // Next state
  always_comb begin
    link_nxt     = link_r;
    poll_nxt     = poll_r;
    rx_count_nxt = rx_count_r;
    tx_pos_nxt   = tx_pos_r;
    tx_rem_nxt   = tx_rem_r;
    crc_nxt      = crc_r;
    sil_cnt_nxt  = sil_cnt_r;
    timer_nxt    = timer_r;
    ram_en       = 1'b0;
    ram_we       = 1'b0;
    ram_addr     = wr_addr;
    case (op)
      OP_RX_BYTE: begin
        if (link_r != LINK_TX_XMIT) begin
          link_nxt     = LINK_RX_RCV;
          rx_count_nxt = rx_base;
          crc_nxt      = crc_base;
          if (rx_store) begin
            rx_count_nxt = rx_base + CNT_W'(1);
            crc_nxt      = crc_add(crc_base, in_data);
            ram_en       = 1'b1;
            ram_we       = 1'b1;
          end
        end
        sil_cnt_nxt = '0;
        timer_nxt   = 1'b1;
      end
      OP_TX_READY: begin
        if (link_r == LINK_TX_XMIT) begin
          if (tx_more) begin
            ram_en     = 1'b1;
            ram_addr   = tx_pos_r[ADDR_W-1:0];
            tx_pos_nxt = tx_pos_r + LEN_W'(1);
            tx_rem_nxt = tx_rem_r - LEN_W'(1);
          end else begin
            link_nxt = LINK_RX_IDLE;
            if (poll_r == POLL_XMIT) begin
              poll_nxt = POLL_WAIT;
            end
          end
        end
      end
      OP_TICK: begin
        if (timer_r) begin
          sil_cnt_nxt = sil_inc;
          if (expire) begin
            if (report) begin
              poll_nxt = POLL_READY;
            end
            timer_nxt   = 1'b0;
            sil_cnt_nxt = '0;
            link_nxt    = LINK_RX_IDLE;
          end
        end
      end
      OP_LOAD: begin
        if (idx_ok) begin
          ram_en = 1'b1;
          ram_we = 1'b1;
        end
      end
      OP_SEND: begin
        if (link_r == LINK_RX_IDLE) begin
          link_nxt   = LINK_TX_XMIT;
          tx_pos_nxt = LEN_W'(1);
          tx_rem_nxt = send_len - LEN_W'(1);
          poll_nxt   = POLL_XMIT;
        end
      end
      OP_READ: begin
        if (idx_ok) begin
          ram_en   = 1'b1;
          ram_addr = in_index[ADDR_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // Result word
  always_comb begin
    res_nxt              = '0;
    res_nxt.poll_phase   = poll_nxt;
    res_nxt.rx_enabled   = (link_nxt != LINK_TX_XMIT);
    case (op)
      OP_TX_READY: begin
        if ((link_r == LINK_TX_XMIT) && tx_more) begin
          res_nxt.tx_valid    = 1'b1;
          res_nxt.tx_from_ram = 1'b1;
        end
      end
      OP_TICK: begin
        if (expire && report) begin
          res_nxt.frame_done = 1'b1;
          if ((rx_count_r >= CNT_W'(3)) && (crc_r == '0)) begin
            res_nxt.frame_ok    = 1'b1;
            res_nxt.slave_addr  = byte0_r;
            res_nxt.func_code   = byte1_r;
            res_nxt.payload_len = (rx_count_r >= CNT_W'(4)) ?
                                  8'(rx_count_r - CNT_W'(4)) : 8'd0;
          end
        end
      end
      OP_SEND: begin
        if (link_r == LINK_RX_IDLE) begin
          res_nxt.tx_valid = 1'b1;
          res_nxt.tx_byte  = byte0_r;
        end else begin
          res_nxt.send_refused = 1'b1;
        end
      end
      OP_READ: begin
        res_nxt.rd_from_ram = idx_ok;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r     <= LINK_RX_IDLE;
      poll_r     <= POLL_IDLE;
      rx_count_r <= '0;
      tx_pos_r   <= '0;
      tx_rem_r   <= '0;
      crc_r      <= CRC_INIT;
      sil_cnt_r  <= '0;
      timer_r    <= 1'b0;
    end else if (in_acc) begin
      link_r     <= link_nxt;
      poll_r     <= poll_nxt;
      rx_count_r <= rx_count_nxt;
      tx_pos_r   <= tx_pos_nxt;
      tx_rem_r   <= tx_rem_nxt;
      crc_r      <= crc_nxt;
      sil_cnt_r  <= sil_cnt_nxt;
      timer_r    <= timer_nxt;
    end
  end

  // Flop copies of buffer bytes 0 and 1.
  always_ff @(posedge clk) begin
    if (in_acc && ram_we) begin
      if (wr_addr == ADDR_W'(0)) begin
        byte0_r <= in_data;
      end
      if (wr_addr == ADDR_W'(1)) begin
        byte1_r <= in_data;
      end
    end
  end

  mbrtu_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_MAX)
  ) u_frame_buf (
    .clk   (clk),
    .en    (in_acc && ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_data),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv_s1) begin
        s1_valid_r <= in_valid;
      end
      if (adv_out) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= res_nxt;
    end
    if (adv_out && s1_valid_r) begin
      out_r         <= s1_r;
      out_tx_byte_r <= s1_r.tx_from_ram ? ram_q : s1_r.tx_byte;
      out_rd_r      <= s1_r.rd_from_ram ? ram_q : 8'd0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tx_valid     = out_r.tx_valid;
  assign out_tx_byte      = out_tx_byte_r;
  assign out_frame_done   = out_r.frame_done;
  assign out_frame_ok     = out_r.frame_ok;
  assign out_slave_addr   = out_r.slave_addr;
  assign out_func_code    = out_r.func_code;
  assign out_payload_len  = out_r.payload_len;
  assign out_read_data    = out_rd_r;
  assign out_poll_phase   = out_r.poll_phase;
  assign out_send_refused = out_r.send_refused;
  assign out_rx_enabled   = out_r.rx_enabled;

  `ASSERT_IMP(a_tx_while_xmit, clk, rst_n, out_valid && out_tx_valid, !out_rx_enabled, "tx word with receiver enabled")
  `ASSERT_IMP(a_ok_needs_done, clk, rst_n, out_valid && out_frame_ok, out_frame_done && (out_poll_phase == POLL_READY), "frame_ok without frame report")
  `ASSERT_IMP(a_rx_count_max, clk, rst_n, 1'b1, rx_count_r <= CNT_W'(FRAME_MAX), "rx count beyond buffer")
  `ASSERT_NXT(a_send_enters_xmit, clk, rst_n, in_acc && (op == OP_SEND) && (link_r == LINK_RX_IDLE), (link_r == LINK_TX_XMIT) && (poll_r == POLL_XMIT), "accepted send did not start transmit")

endmodule
